/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// Command and status codes, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    localparam logic [2:0] CMD_PREPEND = 3'd0;
    localparam logic [2:0] CMD_APPEND  = 3'd1;
    localparam logic [2:0] CMD_INSERT  = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_DUMP    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // most beats a single dump emits
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic       latch;
        logic       start;
        logic       run;
        logic       commit_ins;
        logic       commit_rem;
        logic       load_resp;
        logic [1:0] resp_status;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_ins;
        logic is_rem;
        logic is_dump;
        logic bad_pos;
        logic full;
        logic empty;
        logic scan_done;
        logic found;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* src/ole_datapath.sv */
// ----------------------------------------------------------------------------
// ole_datapath
// Element memory, length count, shift/scan pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire ole_pkg::t_ctrl_cmd i_cmd,
    output ole_pkg::t_dp_sts       o_sts,
    input  wire  [2:0]             i_command,
    input  wire  [4:0]             i_position,
    input  wire  signed [31:0]     i_value,
    input  wire                    i_ready,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [4:0]             o_length,
    output logic signed [31:0]     o_element,
    output logic                   o_element_valid,
    output logic                   o_last
);
    import ole_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int W  = (LW > 5) ? LW : 5;

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;
    logic [AW-1:0]      r_rd_addr;
    logic               r_rd_vld;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      r_ptr;
    logic               r_found;
    logic [2:0]         r_cmd;
    logic [4:0]         r_pos;
    logic signed [31:0] r_val;

    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic [4:0]         r_o_length;
    logic signed [31:0] r_o_element;
    logic               r_o_evalid;
    logic               r_o_last;

    logic [W-1:0]       len_w;
    logic [W-1:0]       pos_w;
    logic [W-1:0]       n_w;
    logic [LW-1:0]      dump_n;
    logic [LW-1:0]      idx;
    logic [LW-1:0]      ptr_dec;
    logic               is_ins;
    logic               is_rem;
    logic               is_dump;
    logic               more;
    logic               out_free;
    logic               issue;
    logic [AW-1:0]      rd_addr;
    logic               scan_wr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               match;
    logic               dump_ld;
    logic               dump_last;
    logic               n_rd_vld;

    always_comb begin
        len_w   = W'(r_len);
        pos_w   = W'(r_pos);
        is_ins  = (r_cmd == CMD_PREPEND) || (r_cmd == CMD_APPEND) || (r_cmd == CMD_INSERT);
        is_rem  = (r_cmd == CMD_REMOVE);
        is_dump = (r_cmd == CMD_DUMP);
        n_w     = (len_w > W'(MAX_RESULTS)) ? W'(MAX_RESULTS) : len_w;
        dump_n  = LW'(n_w);
        case (r_cmd)
            CMD_PREPEND: idx = '0;
            CMD_APPEND:  idx = r_len;
            CMD_INSERT:  idx = LW'(r_pos);
            default:     idx = '0;
        endcase
        ptr_dec  = r_ptr - LW'(1);
        out_free = !r_o_valid || i_ready;
        if (is_ins) begin
            more = r_ptr > idx;
        end else if (is_rem) begin
            more = r_ptr < r_len;
        end else if (is_dump) begin
            more = r_ptr < dump_n;
        end else begin
            more = 1'b0;
        end
        issue   = i_cmd.run && more && (!is_dump || !r_rd_vld || out_free);
        rd_addr = is_ins ? ptr_dec[AW-1:0] : r_ptr[AW-1:0];
        scan_wr = i_cmd.run && r_rd_vld && (is_ins || (is_rem && r_found));
        wr_en   = scan_wr || i_cmd.commit_ins;
        if (i_cmd.commit_ins) begin
            wr_addr = idx[AW-1:0];
        end else if (is_ins) begin
            wr_addr = r_rd_addr + AW'(1);
        end else begin
            wr_addr = r_rd_addr - AW'(1);
        end
        wr_data   = i_cmd.commit_ins ? r_val : r_rd_data;
        match     = i_cmd.run && is_rem && r_rd_vld && !r_found && (r_rd_data == r_val);
        dump_ld   = i_cmd.run && is_dump && r_rd_vld && out_free;
        dump_last = (LW'(r_rd_addr) + LW'(1)) == dump_n;
        n_rd_vld  = issue || (r_rd_vld && is_dump && i_cmd.run && !out_free);
    end

    // memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_val <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ptr    <= '0;
            r_found  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_ptr    <= is_ins ? r_len : '0;
                r_found  <= 1'b0;
                r_rd_vld <= 1'b0;
            end else begin
                if (issue) begin
                    r_ptr <= is_ins ? ptr_dec : r_ptr + LW'(1);
                end
                if (match) begin
                    r_found <= 1'b1;
                end
                r_rd_vld <= n_rd_vld;
            end
            if (i_cmd.commit_ins) begin
                r_len <= r_len + LW'(1);
            end else if (i_cmd.commit_rem && r_found) begin
                r_len <= r_len - LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (dump_ld || i_cmd.load_resp) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dump_ld) begin
            r_o_status  <= ST_OK;
            r_o_length  <= len_w[4:0];
            r_o_element <= r_rd_data;
            r_o_evalid  <= 1'b1;
            r_o_last    <= dump_last;
        end else if (i_cmd.load_resp) begin
            r_o_status  <= i_cmd.resp_status;
            r_o_length  <= len_w[4:0];
            r_o_element <= '0;
            r_o_evalid  <= 1'b0;
            r_o_last    <= 1'b1;
        end
    end

    always_comb begin
        o_sts.is_ins    = is_ins;
        o_sts.is_rem    = is_rem;
        o_sts.is_dump   = is_dump;
        o_sts.bad_pos   = (r_cmd == CMD_INSERT) && (pos_w > len_w);
        o_sts.full      = (r_len == LW'(CAPACITY));
        o_sts.empty     = (r_len == '0);
        o_sts.scan_done = !more && !r_rd_vld;
        o_sts.found     = r_found;
        o_sts.out_free  = out_free;
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_length        = r_o_length;
    assign o_element       = r_o_element;
    assign o_element_valid = r_o_evalid;
    assign o_last          = r_o_last;

`include "assert_macros.svh"

    `ASSERT_IMP(a_len_cap, 1'b1, r_len <= LW'(CAPACITY))
    `ASSERT_IMP(a_wr_excl, i_cmd.commit_ins, !scan_wr)
    `ASSERT_IMP(a_ins_room, i_cmd.commit_ins, !o_sts.full)
    `ASSERT_NXT(a_rem_len, i_cmd.commit_rem && r_found, r_len == $past(r_len) - LW'(1))

endmodule

`default_nettype wire

/* src/ole_ctrl.sv */
// ----------------------------------------------------------------------------
// ole_ctrl
// Command sequencer: decode, scan/shift pass, commit and single-beat reply.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire ole_pkg::t_dp_sts i_sts,
    output ole_pkg::t_ctrl_cmd  o_cmd
);
    import ole_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_resp_status;
    logic [1:0] n_resp_status;
    logic       accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state       = r_state;
        n_resp_status = r_resp_status;
        o_cmd         = '0;
        o_cmd.latch   = accept;
        o_cmd.resp_status = r_resp_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_resp_status = ST_OK;
                if (i_sts.is_ins) begin
                    if (i_sts.bad_pos) begin
                        n_resp_status = ST_BAD_POS;
                        n_state       = S_RESP;
                    end else if (i_sts.full) begin
                        n_resp_status = ST_FULL;
                        n_state       = S_RESP;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end
                end else if (i_sts.is_rem) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end else if (i_sts.is_dump && !i_sts.empty) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                o_cmd.run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.is_dump ? S_IDLE : S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit_ins = i_sts.is_ins;
                o_cmd.commit_rem = i_sts.is_rem;
                n_resp_status    = (i_sts.is_rem && !i_sts.found) ? ST_NOT_FOUND : ST_OK;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_resp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp_status <= n_resp_status;
    end

`include "assert_macros.svh"

    `ASSERT_NXT(a_acc_decide, accept, r_state == S_DECIDE)
    `ASSERT_IMP(a_run_scan, o_cmd.run, r_state == S_SCAN && !o_ready)

endmodule

`default_nettype wire

/* src/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with prepend, append,
// insert, remove and dump commands.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | i_valid / o_ready  | i_command, i_position, i_value
//  result   | o_valid / i_ready  | o_status, o_length, o_element,
//           |                    | o_element_valid, o_last
//
//  o_ready is low from the accepting edge until the command completes.
//  insert/prepend/append shift the elements from index up; remove scans the
//  whole list; rejected, unknown or empty dump go straight to the reply; dump
//  emits n = min(length, MAX_RESULTS) beats, one per cycle unless stalled.
//  Reset clears the list length, not the stored elements; no clearing pass.
//  A waiting result stalls dump reads and the reply beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [2:0]          i_command,
    input  wire  [4:0]          i_position,
    input  wire  signed [31:0]  i_value,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [1:0]          o_status,
    output logic [4:0]          o_length,
    output logic signed [31:0]  o_element,
    output logic                o_element_valid,
    output logic                o_last
);
    import ole_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;

    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (dp_sts),
        .o_cmd   (ctrl_cmd)
    );

    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_sts           (dp_sts),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_length        (o_length),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
